/* src/u16u8_pkg.sv */
`timescale 1ns / 1ps
// Package for the UTF-16 to UTF-8 transcoder: queue entry type, code constants
// and the UTF-8 encoder function. No dependencies.
package u16u8_pkg;

  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] LIM_ONE       = 21'h00080;
  localparam logic [20:0] LIM_TWO       = 21'h00800;
  localparam logic [20:0] LIM_THREE     = 21'h10000;
  localparam logic [7:0]  LEAD_TWO      = 8'hC0;
  localparam logic [7:0]  LEAD_THREE    = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
  localparam logic [7:0]  CONT_MARK     = 8'h80;

  typedef logic [1:0] run_idx_t;

  localparam run_idx_t RUN_ONE   = 2'd0;
  localparam run_idx_t RUN_TWO   = 2'd1;
  localparam run_idx_t RUN_THREE = 2'd2;
  localparam run_idx_t RUN_FOUR  = 2'd3;

  // One queued result run: up to four bytes, index of the final byte,
  // stream-end and error flags.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    run_idx_t        last_idx;
    logic            stream_end;
    logic            error;
  } run_t;

  function automatic run_t encode_cp(input logic [20:0] cp, input logic stream_end);
    run_t r;
    r            = '0;
    r.stream_end = stream_end;
    r.error      = 1'b0;
    if (cp < LIM_ONE) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = RUN_ONE;
    end else if (cp < LIM_TWO) begin
      r.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
      r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      r.last_idx = RUN_TWO;
    end else if (cp < LIM_THREE) begin
      r.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
      r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      r.last_idx = RUN_THREE;
    end else begin
      r.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
      r.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      r.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      r.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      r.last_idx = RUN_FOUR;
    end
    return r;
  endfunction

  function automatic run_t error_run();
    run_t r;
    r            = '0;
    r.last_idx   = RUN_ONE;
    r.stream_end = 1'b1;
    r.error      = 1'b1;
    return r;
  endfunction

endpackage

/* src/u16u8_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the UTF-16 byte input and UTF-8 output.
// No dependencies.
interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface u16u8_utf8_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       run_last;
  logic       stream_end;
  logic       error;

  modport source(output valid, utf8_byte, run_last, stream_end, error, input ready);
  modport sink(input valid, utf8_byte, run_last, stream_end, error, output ready);
endinterface

/* src/u16u8_front.sv */
`timescale 1ns / 1ps
// Front end: pairs input bytes into code units, joins surrogate pairs and
// encodes each code point into a queued run. Uses u16u8_pkg and u16u8_byte_if.
module u16u8_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             big_endian,
  u16u8_byte_if.sink       utf16,
  input  logic             q_full,
  output logic             q_push,
  output u16u8_pkg::run_t  q_data
);

  logic [7:0]  pending_byte;
  logic        have_half_unit;
  logic        in_pair;
  logic [9:0]  held_high_bits;

  logic [7:0]  pending_byte_next;
  logic        have_half_unit_next;
  logic        in_pair_next;
  logic [9:0]  held_high_bits_next;

  logic        take;
  logic [15:0] unit;
  logic [20:0] cp;
  logic        is_high;

  assign utf16.ready = !q_full;
  assign take        = utf16.valid && utf16.ready;

  assign unit    = big_endian ? {pending_byte, utf16.data_byte}
                              : {utf16.data_byte, pending_byte};
  assign is_high = (unit >= u16u8_pkg::HI_SURR_FIRST) && (unit <= u16u8_pkg::HI_SURR_LAST);
  assign cp      = in_pair ? (u16u8_pkg::SUPP_BASE + {1'b0, held_high_bits, unit[9:0]})
                           : {5'b00000, unit};

  always_comb begin
    pending_byte_next   = pending_byte;
    have_half_unit_next = have_half_unit;
    in_pair_next        = in_pair;
    held_high_bits_next = held_high_bits;
    q_push              = 1'b0;
    q_data              = u16u8_pkg::encode_cp(cp, utf16.last_byte);
    if (take) begin
      if (!have_half_unit) begin
        if (utf16.last_byte) begin
          q_push = 1'b1;
          q_data = u16u8_pkg::error_run();
        end else begin
          pending_byte_next   = utf16.data_byte;
          have_half_unit_next = 1'b1;
        end
      end else begin
        have_half_unit_next = 1'b0;
        pending_byte_next   = '0;
        if (in_pair) begin
          in_pair_next        = 1'b0;
          held_high_bits_next = '0;
          q_push              = 1'b1;
        end else if (is_high) begin
          if (utf16.last_byte) begin
            q_push = 1'b1;
            q_data = u16u8_pkg::error_run();
          end else begin
            in_pair_next        = 1'b1;
            held_high_bits_next = unit[9:0];
          end
        end else begin
          q_push = 1'b1;
        end
      end
      // drop all stream state at the end of the buffer
      if (utf16.last_byte) begin
        pending_byte_next   = '0;
        have_half_unit_next = 1'b0;
        in_pair_next        = 1'b0;
        held_high_bits_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte   <= '0;
      have_half_unit <= 1'b0;
      in_pair        <= 1'b0;
      held_high_bits <= '0;
    end else begin
      pending_byte   <= pending_byte_next;
      have_half_unit <= have_half_unit_next;
      in_pair        <= in_pair_next;
      held_high_bits <= held_high_bits_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && utf16.last_byte) |=> (!have_half_unit && !in_pair))
    else $error("stream state not cleared after final byte");

  a_pair_on_unit: assert property (@(posedge clk) disable iff (rst)
    $rose(in_pair) |-> (!have_half_unit && $past(have_half_unit)))
    else $error("high surrogate held without a completed unit");

endmodule

/* src/u16u8_queue.sv */
`timescale 1ns / 1ps
// Short run queue between front and back ends.
// Uses u16u8_pkg for the entry type.
module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u16u8_pkg::run_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output u16u8_pkg::run_t  pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u16u8_pkg::run_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on transfer in");

endmodule

/* src/u16u8_back.sv */
`timescale 1ns / 1ps
// Back end: takes runs from the queue and serializes them one UTF-8 byte
// per output transfer. Uses u16u8_pkg and u16u8_utf8_if.
module u16u8_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  u16u8_pkg::run_t  q_data,
  output logic             q_pop,
  u16u8_utf8_if.source     utf8
);

  u16u8_pkg::run_t  cur;
  logic             busy;
  u16u8_pkg::run_idx_t idx;
  logic             fire;
  logic             at_last;

  assign fire    = utf8.valid && utf8.ready;
  assign at_last = (idx == cur.last_idx);
  assign q_pop   = q_not_empty && (!busy || (fire && at_last));

  assign utf8.valid      = busy;
  assign utf8.utf8_byte  = cur.bytes[idx];
  assign utf8.run_last   = at_last && !cur.error;
  assign utf8.stream_end = at_last && cur.stream_end;
  assign utf8.error      = cur.error;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= cur.last_idx))
    else $error("byte index past end of run");

  a_error_run: assert property (@(posedge clk) disable iff (rst)
    (busy && cur.error) |-> (cur.last_idx == u16u8_pkg::RUN_ONE && utf8.utf8_byte == 8'h00
                             && utf8.stream_end))
    else $error("malformed error result");

endmodule

/* src/utf16_to_utf8_transcoder.sv */
`timescale 1ns / 1ps
// Top level of the UTF-16 to UTF-8 transcoder: front end, run queue, back end
// and the byte-order register. Uses u16u8_pkg, u16u8_ifs and the three submodules.
//
//   channel   dir  handshake     payload
//   utf16     in   valid/ready   data_byte[7:0], last_byte
//   utf8      out  valid/ready   utf8_byte[7:0], run_last, stream_end, error
//   cfg       in   cfg_write     cfg_data = big_endian
//
// One input byte is taken per cycle while the queue has room; a code point's
// run enters the queue in the cycle the second byte of its last code unit is taken.
// The back end sends one UTF-8 byte per cycle while utf8.ready is high, so a
// code point costs 1 to 4 output bytes (3 per 2-byte unit on a 3-byte BMP
// stream, where output serialization sets the sustained rate). Reset (rst,
// synchronous) clears stream state, the queue and big_endian. An output stall
// fills the queue, then drops utf16.ready.
module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  u16u8_byte_if.sink    utf16,
  u16u8_utf8_if.source  utf8
);

  logic            big_endian;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_not_empty;
  u16u8_pkg::run_t q_in;
  u16u8_pkg::run_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
    end else if (cfg_write) begin
      big_endian <= cfg_data;
    end
  end

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .big_endian (big_endian),
    .utf16      (utf16),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  u16u8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .utf8        (utf8)
  );

endmodule
